[src/scfla_pkg.sv]
package scfla_pkg;

  // Per-class slot cap: a slot index is 8 bits wide.
  localparam int SLOTS     = 256;
  localparam int CLASSES   = 4;
  localparam int NUM_LIMIT = 4;

  localparam logic [8:0] SLOT_CAP  = 9'((SLOTS < 256) ? SLOTS : 256);
  localparam logic [8:0] DEPTH_MAX = 9'd511;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_FREED     = 3'd3,
    ST_BAD_SLOT  = 3'd4
  } status_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    REG_LIMIT_0 = 3'd0,
    REG_LIMIT_1 = 3'd1,
    REG_LIMIT_2 = 3'd2,
    REG_LIMIT_3 = 3'd3,
    REG_COUNT_0 = 3'd4,
    REG_COUNT_1 = 3'd5,
    REG_COUNT_2 = 3'd6,
    REG_COUNT_3 = 3'd7
  } cfg_reg_t;

  localparam logic [15:0] LIMIT_RST_0 = 16'd64;
  localparam logic [15:0] LIMIT_RST_1 = 16'd256;
  localparam logic [15:0] LIMIT_RST_2 = 16'd1024;
  localparam logic [15:0] LIMIT_RST_3 = 16'd4096;
  localparam logic [8:0]  COUNT_RST   = 9'd256;

endpackage

[src/size_class_free_list_allocator.sv]
// Segregated free-list allocator, status only. Each transaction is an allocate
// (request length mapped to the first size class whose limit covers it) or a free
// (class and slot pushed back). Because the result carries only a status code, the
// block keeps per-class occupancy: the free-list depth and the bump counter of
// never-used slots; the identity of the slot on top of each list does not reach
// the output and is not stored. One transaction is taken per clock while the output
// is not stalled: an input register feeds combinational compare-and-update against
// the per-class counters, and the result is captured in an output register that
// drives out_valid. Write configuration only while no transaction is in flight.
module size_class_free_list_allocator #(
  parameter int CLASSES = scfla_pkg::CLASSES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [15:0] in_request_length,
  input  logic [1:0]  in_class_index,
  input  logic [7:0]  in_slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status
);
  import scfla_pkg::*;

  logic [15:0] limit_r [NUM_LIMIT];
  logic [8:0]  count_r [NUM_LIMIT];
  logic [8:0]  depth_r [CLASSES];
  logic [8:0]  depth_nxt [CLASSES];
  logic [8:0]  bump_r [CLASSES];
  logic [8:0]  bump_nxt [CLASSES];

  logic        in_vld_r;
  logic        kind_r;
  logic [15:0] len_r;
  logic [1:0]  cls_r;
  logic [7:0]  slot_r;

  logic        out_vld_r;
  status_t     status_r;
  status_t     status_nxt;

  logic        adv;
  logic        step;

  logic [CLASSES-1:0] hit;
  logic [CLASSES-1:0] asel;
  logic [CLASSES-1:0] fsel;
  logic [8:0]         eff [CLASSES];
  logic               found;
  logic               too_long;
  logic               can_pop;
  logic               can_bump;
  logic               free_ok;

  // Result register is free, or is being taken this cycle.
  assign adv      = !out_vld_r || !out_stall;
  assign step     = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;

  assign out_valid  = out_vld_r;
  assign out_status = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r[0] <= LIMIT_RST_0;
      limit_r[1] <= LIMIT_RST_1;
      limit_r[2] <= LIMIT_RST_2;
      limit_r[3] <= LIMIT_RST_3;
      for (int i = 0; i < NUM_LIMIT; i++) begin
        count_r[i] <= COUNT_RST;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LIMIT_0: limit_r[0] <= cfg_wdata;
        REG_LIMIT_1: limit_r[1] <= cfg_wdata;
        REG_LIMIT_2: limit_r[2] <= cfg_wdata;
        REG_LIMIT_3: limit_r[3] <= cfg_wdata;
        REG_COUNT_0: count_r[0] <= cfg_wdata[8:0];
        REG_COUNT_1: count_r[1] <= cfg_wdata[8:0];
        REG_COUNT_2: count_r[2] <= cfg_wdata[8:0];
        REG_COUNT_3: count_r[3] <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (adv || !in_vld_r) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_r <= in_kind;
      len_r  <= in_request_length;
      cls_r  <= in_class_index;
      slot_r <= in_slot_index;
    end
  end

  always_comb begin
    found    = 1'b0;
    can_pop  = 1'b0;
    can_bump = 1'b0;
    free_ok  = 1'b0;
    for (int c = 0; c < CLASSES; c++) begin
      eff[c]  = (count_r[c] > SLOT_CAP) ? SLOT_CAP : count_r[c];
      hit[c]  = len_r <= limit_r[c];
      // First class that covers the request wins.
      asel[c] = hit[c] && !found;
      found   = found || hit[c];
      fsel[c] = cls_r == 2'(c);
      if (asel[c]) begin
        can_pop  = depth_r[c] != 9'd0;
        can_bump = bump_r[c] < eff[c];
      end
      if (fsel[c]) begin
        free_ok = {1'b0, slot_r} < eff[c];
      end
    end
    too_long = !hit[CLASSES-1];

    if (kind_r == KIND_FREE) begin
      status_nxt = free_ok ? ST_FREED : ST_BAD_SLOT;
    end else if (too_long) begin
      status_nxt = ST_TOO_LONG;
    end else if (can_pop || can_bump) begin
      status_nxt = ST_GRANTED;
    end else begin
      status_nxt = ST_EXHAUSTED;
    end

    for (int c = 0; c < CLASSES; c++) begin
      depth_nxt[c] = depth_r[c];
      bump_nxt[c]  = bump_r[c];
      if (step) begin
        if (kind_r == KIND_FREE) begin
          if (fsel[c] && free_ok && depth_r[c] != DEPTH_MAX) begin
            depth_nxt[c] = depth_r[c] + 9'd1;
          end
        end else if (asel[c] && !too_long) begin
          // Reuse a freed slot before touching never-used ones.
          if (can_pop) begin
            depth_nxt[c] = depth_r[c] - 9'd1;
          end else if (can_bump) begin
            bump_nxt[c] = bump_r[c] + 9'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CLASSES; c++) begin
        depth_r[c] <= '0;
        bump_r[c]  <= '0;
      end
    end else begin
      for (int c = 0; c < CLASSES; c++) begin
        depth_r[c] <= depth_nxt[c];
        bump_r[c]  <= bump_nxt[c];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      status_r <= status_nxt;
    end
  end

  a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && out_stall |-> in_stall)
    else $error("input stage not held behind a stalled result");

  a_idle_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(depth_r[0]) && $stable(bump_r[0]))
    else $error("class state changed without a transaction");

  a_bump_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r[0] <= SLOT_CAP)
    else $error("bump counter ran past the slot cap");

  a_grant_moves_state: assert property (@(posedge clk) disable iff (!rst_n)
    step && asel[0] && kind_r == KIND_ALLOC && status_nxt == ST_GRANTED
      |=> !$stable(depth_r[0]) || !$stable(bump_r[0]))
    else $error("grant left class occupancy unchanged");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import scfla_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [15:0] in_request_length;
  logic [1:0]  in_class_index;
  logic [7:0]  in_slot_index;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;

  typedef struct {
    kind_t       kind;
    logic [15:0] len;
    logic [1:0]  cls;
    logic [7:0]  slot;
    bit          fixed;
    status_t     want;
  } dir_row_t;

  // Occupancy model: per-class limits, slot counts, free-stack depth, fresh slots taken
  logic [15:0] class_limit [NUM_LIMIT];
  logic [8:0]  class_slots [NUM_LIMIT];
  logic [8:0]  stack_len   [NUM_LIMIT];
  logic [8:0]  fresh_taken [NUM_LIMIT];

  status_t  pending_status [$];
  status_t  exp_status;
  dir_row_t dir_rows [21];
  int       errors;
  int       accepted;
  int       cycles;
  int       send_idle_pct;
  int       recv_idle_pct;
  logic     hold_out;

  size_class_free_list_allocator DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_request_length (in_request_length),
    .in_class_index    (in_class_index),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [8:0] usable_slots(input logic [1:0] c);
    return (class_slots[c] > SLOT_CAP) ? SLOT_CAP : class_slots[c];
  endfunction

  function automatic status_t predict_status(input kind_t kind, input logic [15:0] len,
                                             input logic [1:0] c, input logic [7:0] slot);
    int hit;
    hit = CLASSES - 1;
    if (kind == KIND_FREE) begin
      if (int'(c) >= CLASSES || {1'b0, slot} >= usable_slots(c)) return ST_BAD_SLOT;
      if (stack_len[c] != DEPTH_MAX) stack_len[c]++;
      return ST_FREED;
    end
    if (len > class_limit[CLASSES - 1]) return ST_TOO_LONG;
    // first class whose limit covers the request, no fallback
    for (int i = CLASSES - 1; i >= 0; i--) begin
      if (len <= class_limit[i]) hit = i;
    end
    if (stack_len[hit] != 0) begin
      stack_len[hit]--;
      return ST_GRANTED;
    end
    if (fresh_taken[hit] < usable_slots(2'(hit))) begin
      fresh_taken[hit]++;
      return ST_GRANTED;
    end
    return ST_EXHAUSTED;
  endfunction

  task automatic offer(input kind_t kind, input logic [15:0] len, input logic [1:0] c,
                       input logic [7:0] slot, input bit fixed, input status_t want);
    status_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_kind           <= kind;
    in_request_length <= len;
    in_class_index    <= c;
    in_slot_index     <= slot;
    do @(posedge clk); while (in_stall);
    predicted = predict_status(kind, len, c, slot);
    pending_status.push_back(fixed ? want : predicted);
    accepted++;
  endtask

  task automatic random_item(input int free_pct);
    kind_t       kind;
    logic [15:0] len;
    logic [1:0]  c;
    logic [7:0]  slot;
    logic [15:0] lo;
    int          roll;
    kind = KIND_ALLOC;
    len  = 16'($urandom);
    c    = 2'($urandom);
    slot = 8'($urandom);
    roll = $urandom_range(99);
    if (roll < free_pct) begin
      kind = KIND_FREE;
      // mostly legal slots, the rest anything the field allows
      if (roll < free_pct * 9 / 10 && usable_slots(c) != 0)
        slot = 8'($urandom_range(usable_slots(c) - 1, 0));
    end else if (roll < 92) begin
      lo = (c == 0 || class_limit[c - 1] >= class_limit[c]) ? 16'd0
                                                          : class_limit[c - 1] + 16'd1;
      len = 16'($urandom_range(class_limit[c], lo));
    end
    offer(kind, len, c, slot, 1'b0, ST_GRANTED);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx < REG_COUNT_0) class_limit[idx[1:0]] = val;
    else class_slots[idx[1:0]] = val[8:0];
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= hold_out || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Long receiver hold-off so the pipeline fills and backs up the input
  initial begin
    hold_out = 1'b0;
    do @(posedge clk); while (accepted < 40);
    hold_out <= 1'b1;
    repeat (120) @(posedge clk);
    hold_out <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: status %0d", out_status);
      end else begin
        exp_status = pending_status.pop_front();
        if (out_status !== exp_status) begin
          errors++;
          if (errors <= 10)
            $display("status mismatch: expected %0d, got %0d", exp_status, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = REG_LIMIT_0;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_kind           = KIND_ALLOC;
    in_request_length = '0;
    in_class_index    = '0;
    in_slot_index     = '0;
    errors            = 0;
    accepted          = 0;
    cycles            = 0;
    send_idle_pct     = 26;
    recv_idle_pct     = 74;
    class_limit       = '{LIMIT_RST_0, LIMIT_RST_1, LIMIT_RST_2, LIMIT_RST_3};
    class_slots       = '{COUNT_RST, COUNT_RST, COUNT_RST, COUNT_RST};
    stack_len         = '{default: '0};
    fresh_taken       = '{default: '0};

    // class two holds one slot, class three none
    dir_rows = '{
      '{KIND_ALLOC, 16'd0,     2'd0, 8'd0,   1'b1, ST_GRANTED},
      '{KIND_ALLOC, 16'd64,    2'd0, 8'd0,   1'b1, ST_GRANTED},
      '{KIND_ALLOC, 16'd65,    2'd0, 8'd0,   1'b1, ST_GRANTED},
      '{KIND_ALLOC, 16'd4096,  2'd0, 8'd0,   1'b1, ST_EXHAUSTED},
      '{KIND_ALLOC, 16'd4097,  2'd0, 8'd0,   1'b1, ST_TOO_LONG},
      '{KIND_ALLOC, 16'hFFFF,  2'd3, 8'hFF,  1'b1, ST_TOO_LONG},
      '{KIND_ALLOC, 16'd1000,  2'd0, 8'd0,   1'b1, ST_GRANTED},
      '{KIND_ALLOC, 16'd1024,  2'd0, 8'd0,   1'b1, ST_EXHAUSTED},
      '{KIND_FREE,  16'd0,     2'd2, 8'd1,   1'b1, ST_BAD_SLOT},
      '{KIND_FREE,  16'd0,     2'd2, 8'd0,   1'b1, ST_FREED},
      '{KIND_ALLOC, 16'd257,   2'd0, 8'd0,   1'b1, ST_GRANTED},
      '{KIND_ALLOC, 16'd300,   2'd0, 8'd0,   1'b1, ST_EXHAUSTED},
      '{KIND_FREE,  16'd0,     2'd3, 8'd0,   1'b1, ST_BAD_SLOT},
      '{KIND_FREE,  16'hFFFF,  2'd0, 8'd255, 1'b1, ST_FREED},
      '{KIND_FREE,  16'd0,     2'd1, 8'd200, 1'b1, ST_FREED},
      '{KIND_FREE,  16'd0,     2'd1, 8'd200, 1'b1, ST_FREED},
      '{KIND_ALLOC, 16'd128,   2'd0, 8'd0,   1'b0, ST_GRANTED},
      '{KIND_ALLOC, 16'd200,   2'd0, 8'd0,   1'b0, ST_GRANTED},
      '{KIND_ALLOC, 16'd256,   2'd0, 8'd0,   1'b0, ST_GRANTED},
      '{KIND_FREE,  16'd0,     2'd0, 8'd0,   1'b1, ST_FREED},
      '{KIND_ALLOC, 16'd1,     2'd0, 8'd0,   1'b0, ST_GRANTED}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_COUNT_2, 16'hFE01);
    write_reg(REG_COUNT_3, 16'h0000);
    foreach (dir_rows[i])
      offer(dir_rows[i].kind, dir_rows[i].len, dir_rows[i].cls, dir_rows[i].slot,
            dir_rows[i].fixed, dir_rows[i].want);
    drain();

    // small pools, non-monotone limits, widest last limit
    write_reg(REG_LIMIT_0, 16'd0);
    write_reg(REG_LIMIT_1, 16'd300);
    write_reg(REG_LIMIT_2, 16'd200);
    write_reg(REG_LIMIT_3, 16'hFFFF);
    write_reg(REG_COUNT_0, 16'd3);
    write_reg(REG_COUNT_1, 16'd8);
    write_reg(REG_COUNT_2, 16'd0);
    write_reg(REG_COUNT_3, 16'h01FF);
    repeat (70) random_item(40);
    drain();

    send_idle_pct = 74;
    recv_idle_pct <= 26;
    // lowering class three below what is already handed out
    write_reg(REG_LIMIT_0, 16'd10);
    write_reg(REG_LIMIT_1, 16'd1000);
    write_reg(REG_LIMIT_2, 16'd5000);
    write_reg(REG_LIMIT_3, 16'd20000);
    write_reg(REG_COUNT_0, 16'h0100);
    write_reg(REG_COUNT_1, 16'd1);
    write_reg(REG_COUNT_2, 16'hFE10);
    write_reg(REG_COUNT_3, 16'd2);
    repeat (70) random_item(45);
    drain();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    write_reg(REG_LIMIT_0, LIMIT_RST_0);
    write_reg(REG_LIMIT_1, LIMIT_RST_1);
    write_reg(REG_LIMIT_2, LIMIT_RST_2);
    write_reg(REG_LIMIT_3, LIMIT_RST_3);
    write_reg(REG_COUNT_0, 16'hFFFF);
    write_reg(REG_COUNT_1, COUNT_RST);
    write_reg(REG_COUNT_2, COUNT_RST);
    write_reg(REG_COUNT_3, COUNT_RST);
    // push class one past the depth saturation point, then mix in random traffic
    repeat (520) offer(KIND_FREE, 16'($urandom), 2'd1, 8'($urandom), 1'b0, ST_GRANTED);
    repeat (20) random_item(20);

    drain();
    repeat (6) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
